[hw/rtl/dda_pkg.sv]
// shared constants and control types of the decimal digit analyzer
package dda_pkg;

  // field widths
  localparam int unsigned ValueW = 31;
  localparam int unsigned DigitW = 4;
  localparam int unsigned CountW = 4;
  localparam int unsigned SumW   = 7;
  localparam int unsigned RevW   = 34;

  // at most this many low-order digits are examined
  localparam int unsigned MaxDigits = 10;
  localparam int unsigned DigitCntW = $clog2(MaxDigits + 1);

  // divide by ten as multiply by ceil(2^35 / 10), valid for 32-bit operands
  localparam logic [31:0] Recip10 = 32'hCCCC_CCCD;
  localparam int unsigned Recip10Shift = 35;

  // controller states
  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } dda_state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic step;
    logic publish;
  } dda_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic done;
  } dda_sts_t;

endpackage

[hw/rtl/dda_ifs.sv]
// request channels of the decimal digit analyzer

interface dda_in_if;
  logic                             valid;
  logic                             ready;
  logic [dda_pkg::ValueW-1:0]       value;

  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

interface dda_out_if;
  logic                             valid;
  logic                             ready;
  logic [dda_pkg::CountW-1:0]       even_digit_count;
  logic [dda_pkg::SumW-1:0]         digit_sum;
  logic                             digit_found;
  logic [dda_pkg::RevW-1:0]         reversed_value;
  logic                             value_is_even;

  modport source (output valid, output even_digit_count, output digit_sum,
                  output digit_found, output reversed_value, output value_is_even,
                  input ready);
  modport sink (input valid, input even_digit_count, input digit_sum,
                input digit_found, input reversed_value, input value_is_even,
                output ready);
endinterface

interface dda_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [dda_pkg::DigitW-1:0]       query_digit;

  modport source (output valid, output query_digit, input ready);
  modport sink (input valid, input query_digit, output ready);
endinterface

[hw/rtl/dda_ctrl.sv]
// controller state machine of the decimal digit analyzer
module dda_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  dda_pkg::dda_sts_t sts,
  output dda_pkg::dda_cmd_t cmd
);

  dda_pkg::dda_state_t state_r, state_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                slot_free;

  // result register can take a new result
  assign slot_free = !out_valid_r || out_ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      dda_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = dda_pkg::ST_RUN;
      end
      dda_pkg::ST_RUN: begin
        if (sts.done && slot_free) state_nxt = dda_pkg::ST_IDLE;
      end
      default: state_nxt = dda_pkg::ST_IDLE;
    endcase
  end

  // commands and handshake
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      dda_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      dda_pkg::ST_RUN: begin
        cmd.step    = !sts.done;
        cmd.publish = sts.done && slot_free;
      end
      default: begin
        cmd      = '0;
        in_ready = 1'b0;
      end
    endcase
  end

  // result valid flag
  always_comb begin
    if (cmd.publish) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dda_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[hw/rtl/dda_datapath.sv]
// digit extraction datapath: divide by ten per cycle, accumulators, result register
module dda_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  dda_pkg::dda_cmd_t             cmd,
  output dda_pkg::dda_sts_t             sts,
  input  logic [dda_pkg::ValueW-1:0]    value,
  input  logic                          cfg_we,
  input  logic [dda_pkg::DigitW-1:0]    cfg_query,
  output logic [dda_pkg::CountW-1:0]    even_digit_count,
  output logic [dda_pkg::SumW-1:0]      digit_sum,
  output logic                          digit_found,
  output logic [dda_pkg::RevW-1:0]      reversed_value,
  output logic                          value_is_even
);

  logic [dda_pkg::DigitW-1:0]    query_r;
  logic [dda_pkg::ValueW-1:0]    rest_r;
  logic [dda_pkg::ValueW-1:0]    quot_r;
  logic [dda_pkg::DigitCntW-1:0] n_r;
  logic [dda_pkg::CountW-1:0]    evens_r;
  logic [dda_pkg::SumW-1:0]      sum_r;
  logic                          found_r;
  logic [dda_pkg::RevW-1:0]      rev_r;
  logic                          even_r;

  logic [dda_pkg::ValueW-1:0]    mul_in;
  logic [63:0]                   prod;
  logic [dda_pkg::ValueW-1:0]    quot_nxt;
  logic [dda_pkg::ValueW-1:0]    rem_w;
  logic [dda_pkg::DigitW-1:0]    digit;
  logic [dda_pkg::RevW-1:0]      rev_nxt;

  // query register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      query_r <= '0;
    end else if (cfg_we) begin
      query_r <= cfg_query;
    end
  end

  // shared divide-by-ten unit, fed by the new value or the running quotient
  assign mul_in   = cmd.load ? value : quot_r;
  assign prod     = 64'(mul_in) * 64'(dda_pkg::Recip10);
  assign quot_nxt = dda_pkg::ValueW'(prod >> dda_pkg::Recip10Shift);

  // current digit is remainder of rest by ten
  assign rem_w = rest_r - ((quot_r << 3) + (quot_r << 1));
  assign digit = rem_w[dda_pkg::DigitW-1:0];

  // reversed value grows by one digit
  assign rev_nxt = (rev_r << 3) + (rev_r << 1) + dda_pkg::RevW'(digit);

  // loop ends when the remaining value is zero or at the digit limit
  assign sts.done = (rest_r == '0) ||
                    (n_r == dda_pkg::DigitCntW'(dda_pkg::MaxDigits));

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rest_r  <= value;
      quot_r  <= quot_nxt;
      n_r     <= '0;
      evens_r <= '0;
      sum_r   <= '0;
      found_r <= 1'b0;
      rev_r   <= '0;
      even_r  <= ~value[0];
    end else if (cmd.step) begin
      rest_r  <= quot_r;
      quot_r  <= quot_nxt;
      n_r     <= n_r + 1'b1;
      evens_r <= evens_r + dda_pkg::CountW'(!digit[0]);
      sum_r   <= sum_r + dda_pkg::SumW'(digit);
      found_r <= found_r || (digit == query_r);
      rev_r   <= rev_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      even_digit_count <= evens_r;
      digit_sum        <= sum_r;
      digit_found      <= found_r;
      reversed_value   <= rev_r;
      value_is_even    <= even_r;
    end
  end

endmodule

[hw/rtl/decimal_digit_analyzer.sv]
// top level of the decimal digit analyzer
// Splits each 31-bit request value into decimal digits, least significant first,
// and returns the even-digit count, the digit sum, whether the query digit occurs,
// the digit-reversed value and the parity of the value. One request is in work at
// a time: it is accepted, its decimal digits are taken in turn, and the result is
// moved into the output register once that register is free. The digits come
// from the single divide-by-ten unit, a reciprocal multiply that yields one digit
// per cycle. A finished result waits in the output register while the next
// request is taken. The query digit register resets to 0 and is written through
// the cfg channel; the user must write it only while the block is idle, which the
// block itself does not enforce. Its ready is always high.
module decimal_digit_analyzer (
  input  logic      clk,
  input  logic      rst_n,
  dda_in_if.sink    in_ch,
  dda_out_if.source out_ch,
  dda_cfg_if.sink   cfg_ch
);

  dda_pkg::dda_cmd_t cmd;
  dda_pkg::dda_sts_t sts;

  // configuration always accepted
  assign cfg_ch.ready = 1'b1;

  // controller
  dda_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath
  dda_datapath u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .value            (in_ch.value),
    .cfg_we           (cfg_ch.valid),
    .cfg_query        (cfg_ch.query_digit),
    .even_digit_count (out_ch.even_digit_count),
    .digit_sum        (out_ch.digit_sum),
    .digit_found      (out_ch.digit_found),
    .reversed_value   (out_ch.reversed_value),
    .value_is_even    (out_ch.value_is_even)
  );

endmodule
